>>> hdl/xksbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xksbc_pkg
// Shared constants and helpers for the xor keystream byte cipher.
// ----------------------------------------------------------------------------
package xksbc_pkg;

  localparam int LINE_LENGTH_DEF  = 55;
  localparam int TAP_POSITION_DEF = 29;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] LCG_MUL = 8'd109;
  localparam logic [BYTE_W-1:0] LCG_ADD = 8'd57;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  typedef logic [BYTE_W-1:0] byte_t;

  // input function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_CIPHER = 1'b1;

  // keystream source codes
  localparam logic MODE_LCG = 1'b0;
  localparam logic MODE_SUB = 1'b1;

  // low byte of the linear congruential step
  function automatic byte_t lcg_byte(input byte_t k);
    logic [2*BYTE_W-1:0] prod;
    begin
      prod = {{BYTE_W{1'b0}}, k} * {{BYTE_W{1'b0}}, LCG_MUL};
      return prod[BYTE_W-1:0] + LCG_ADD;
    end
  endfunction

endpackage

>>> hdl/xksbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xksbc_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module xksbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 55
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // a read of the entry written on the same edge returns the old word
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/xor_keystream_byte_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_keystream_byte_cipher
// Byte stream cipher: xor of each data byte with an lcg or subtractive
// keystream byte, with a fix-up on the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries func and data. A load word
//   (func = 0) shifts data into the key delay line and sets the running key;
//   it yields no output. A cipher word (func = 1) yields one cipher_byte on
//   the output channel (out_valid / out_stall), in order.
//   mode is written through cfg_write / cfg_data; the user must do so only
//   while the block is idle, which the block does not enforce. Throughput
//   is one word per cycle while in_stall is low. A cipher word passes the
//   registered line head and tap memory reads, then the output register.
//   The delay line is a circular buffer in two RAM copies, one per read
//   address; per-entry valid flops make unwritten entries read as zero.
//   Reset is synchronous: mode, running key and line read as zero right
//   after reset, with no clearing pass. When the receiver stalls, the result
//   holds in the output register and one more cipher word can wait behind
//   it; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module xor_keystream_byte_cipher
  import xksbc_pkg::*;
#(
  parameter int LINE_LENGTH  = LINE_LENGTH_DEF,
  parameter int TAP_POSITION = TAP_POSITION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [BYTE_W-1:0] data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] cipher_byte
);

  localparam int AW  = $clog2(LINE_LENGTH);
  localparam int AW1 = AW + 1;
  localparam int TAP_OFF = TAP_POSITION % LINE_LENGTH;

  logic                   mode;
  byte_t                  running_key;
  byte_t                  last_byte;
  logic [AW-1:0]          head;
  logic [AW-1:0]          head_next;
  logic [AW-1:0]          tap_addr;
  logic [AW1-1:0]         tap_sum;
  logic [LINE_LENGTH-1:0] line_valid;

  logic  accept;
  logic  cipher_accept;
  logic  is_sub;
  logic  wr_en;
  byte_t wr_data;
  logic  rd_en;
  byte_t key_lcg;

  logic  s1_valid;
  logic  s1_adv;
  logic  s1_sub;
  byte_t s1_data;
  byte_t s1_lcg_r;
  logic  s1_head_ok;
  logic  s1_tap_ok;
  byte_t head_q;
  byte_t tap_q;
  byte_t r;
  byte_t r1;
  byte_t x;
  byte_t cipher_next;

  assign accept        = in_valid && !in_stall;
  assign cipher_accept = accept && (func == FUNC_CIPHER);
  assign is_sub        = (mode == MODE_SUB);
  assign key_lcg       = lcg_byte(running_key);

  // loads always shift the line; subtractive ciphers shift in lcg of the tail
  assign wr_en   = accept && ((func == FUNC_LOAD) || is_sub);
  assign wr_data = (func == FUNC_LOAD) ? data : lcg_byte(last_byte);
  assign rd_en   = cipher_accept && is_sub;

  assign head_next = (head == AW'(LINE_LENGTH - 1)) ? '0 : head + AW'(1);
  assign tap_sum   = {1'b0, head} + AW1'(TAP_OFF);
  assign tap_addr  = (tap_sum >= AW1'(LINE_LENGTH)) ?
                     AW'(tap_sum - AW1'(LINE_LENGTH)) : tap_sum[AW-1:0];

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  xksbc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_LENGTH)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (head_q)
  );

  xksbc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_LENGTH)
  ) u_tap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (tap_addr),
    .rd_data (tap_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_LCG;
      running_key <= '0;
      last_byte   <= '0;
      head        <= '0;
      line_valid  <= '0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (accept && (func == FUNC_LOAD)) begin
        running_key <= data;
      end else if (cipher_accept && !is_sub) begin
        running_key <= key_lcg;
      end
      if (wr_en) begin
        last_byte        <= wr_data;
        head             <= head_next;
        line_valid[head] <= 1'b1;
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= cipher_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cipher_accept) begin
      s1_sub     <= is_sub;
      s1_data    <= data;
      s1_lcg_r   <= key_lcg;
      s1_head_ok <= line_valid[head];
      s1_tap_ok  <= line_valid[tap_addr];
    end
  end

  always_comb begin
    if (s1_sub) begin
      r = (s1_tap_ok ? tap_q : '0) - (s1_head_ok ? head_q : '0);
    end else begin
      r = s1_lcg_r;
    end
    r1 = r + 8'd1;
    x  = s1_data ^ r;
    // fix up when the data equals the keystream byte or the xor equals its successor
    if ((s1_data == r) || ((r != BYTE_MAX) && (x == r1))) begin
      cipher_next = s1_data ^ r1;
    end else begin
      cipher_next = x;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cipher_byte <= cipher_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with no word held");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < AW1'(LINE_LENGTH))
    else $error("line head out of range");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_data)))
    else $error("blocked read stage word lost");

  a_load_sets_key: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_LOAD)) |=> (running_key == $past(data)))
    else $error("load did not set running key");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (line_valid[$past(head)] && (last_byte == $past(wr_data))))
    else $error("line write not tracked");
`endif

endmodule

>>> tb/tb_xor_keystream_byte_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_keystream_byte_cipher
// Self-checking bench for the xor keystream byte cipher. A queue-fed driver
// offers key loads and cipher words in random bursts, the receiver stalls on
// its own pattern, and a scoreboard predicts every cipher byte in both
// keystream modes, fix-up cases included, and compares in order.
// ----------------------------------------------------------------------------
module tb_xor_keystream_byte_cipher;
  import xksbc_pkg::*;

  localparam int LINE_LEN    = LINE_LENGTH_DEF;
  localparam int TAP_POS     = TAP_POSITION_DEF;
  localparam int LINE_BITS   = LINE_LEN * BYTE_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 190;

  typedef struct packed {
    byte_t                key;
    logic [LINE_BITS-1:0] line;   // entry i at bits [i*8 +: 8]
  } key_state_t;

  typedef enum logic {W_ITEM, W_PAUSE} word_kind_t;

  typedef struct packed {
    word_kind_t kind;
    logic       func;
    byte_t      data;
  } word_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_kind_t;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  cfg_write = 1'b0;
  logic  cfg_data  = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  logic  func      = 1'b0;
  byte_t data      = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t cipher_byte;

  xor_keystream_byte_cipher u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .data       (data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cipher_byte(cipher_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic byte_t lcg8(byte_t k);
    return byte_t'(k * LCG_MUL + LCG_ADD);
  endfunction

  function automatic byte_t keystream_byte(key_state_t s, logic m);
    byte_t head;
    byte_t tap;
    head = s.line[BYTE_W-1:0];
    tap  = s.line[TAP_POS*BYTE_W +: BYTE_W];
    if (m == MODE_LCG) return lcg8(s.key);
    return tap - head;
  endfunction

  function automatic key_state_t step_key_state(key_state_t s, logic m, logic f, byte_t d);
    if (f == FUNC_LOAD) begin
      s.line = {d, s.line[LINE_BITS-1:BYTE_W]};
      s.key  = d;
    end else if (m == MODE_LCG) begin
      s.key = lcg8(s.key);
    end else begin
      s.line = {lcg8(s.line[LINE_BITS-1 -: BYTE_W]), s.line[LINE_BITS-1:BYTE_W]};
    end
    return s;
  endfunction

  function automatic byte_t fix_up_xor(byte_t d, byte_t r);
    byte_t r1;
    r1 = r + 8'd1;
    if (d == r || (r != BYTE_MAX && (d ^ r) == r1)) return d ^ r1;
    return d ^ r;
  endfunction

  // --------------------------------------------------------------- scoreboard
  key_state_t pred_st   = '0;
  logic       pred_mode = MODE_LCG;
  byte_t      cipher_due[$];
  word_t      pending[$];
  int         accepted_n = 0;
  int         queued_n   = 0;
  int         loads_n    = 0;
  int         ciphers_n  = 0;
  int         fixups_n   = 0;
  int         errors     = 0;
  logic       in_taken   = 1'b0;

  always @(posedge clk) begin
    byte_t r;
    byte_t want;
    if (!rst) begin
      if (cfg_write) pred_mode = cfg_data;
      if (in_valid && !in_stall) begin
        accepted_n++;
        if (func == FUNC_CIPHER) begin
          r    = keystream_byte(pred_st, pred_mode);
          want = fix_up_xor(data, r);
          if (want != (data ^ r)) fixups_n++;
          cipher_due.push_back(want);
          ciphers_n++;
        end else begin
          loads_n++;
        end
        pred_st = step_key_state(pred_st, pred_mode, func, data);
      end
      if (out_valid && !out_stall) begin
        if (cipher_due.size() == 0) begin
          $error("unexpected output word: cipher_byte %02h", cipher_byte);
          errors++;
        end else begin
          want = cipher_due.pop_front();
          if (cipher_byte !== want) begin
            $error("cipher_byte mismatch: expected %02h, actual %02h", want, cipher_byte);
            errors++;
          end
        end
      end
    end
    in_taken = !rst && in_valid && !in_stall;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------ driver
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    word_t w;
    logic  give;
    give = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      // a pause word holds the sender until every cipher byte is back
      while (pending.size() != 0 && pending[0].kind == W_PAUSE && cipher_due.size() == 0)
        w = pending.pop_front();
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending.size() != 0 && pending[0].kind == W_ITEM) begin
        w    = pending.pop_front();
        give = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (give) begin
        func <= w.func;
        data <= w.data;
      end else begin
        func <= 1'($urandom_range(0, 1));
        data <= byte_t'($urandom_range(0, 255));
      end
      in_valid <= give;
    end
  end

  // ---------------------------------------------------------------- receiver
  stall_kind_t seg_kind = STALL_NONE;
  int          seg_left = 0;
  int          seg_no   = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_no++;
        // second segment is always a long hold so the block backs up
        if (seg_no == 2 || $urandom_range(0, 15) == 0) begin
          seg_kind = STALL_HOLD;
          seg_left = $urandom_range(40, 90);
        end else begin
          seg_kind = stall_kind_t'($urandom_range(0, 2));
          seg_left = $urandom_range(10, 60);
        end
      end
      seg_left--;
      case (seg_kind)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------- stimulus
  key_state_t plan_st   = '0;
  logic       plan_mode = MODE_LCG;

  task automatic queue_word(logic f, byte_t d);
    pending.push_back('{kind: W_ITEM, func: f, data: d});
    plan_st = step_key_state(plan_st, plan_mode, f, d);
    queued_n++;
  endtask

  task automatic queue_pause();
    pending.push_back('{kind: W_PAUSE, func: FUNC_LOAD, data: '0});
  endtask

  // data that trips the fix-up on the next cipher word
  function automatic byte_t fixup_data(logic near);
    byte_t r;
    r = keystream_byte(plan_st, plan_mode);
    return near ? byte_t'(r ^ (r + 8'd1)) : r;
  endfunction

  function automatic byte_t key_for_byte(byte_t want);
    byte_t k;
    k = '0;
    repeat (256) begin
      if (lcg8(k) == want) return k;
      k++;
    end
    return '0;
  endfunction

  task automatic wait_idle();
    while (accepted_n != queued_n || cipher_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(logic m);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
    plan_mode = m;
  endtask

  initial begin
    byte_t top_key;
    byte_t d;
    logic  f;
    int    budget;
    int    run;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: lcg keystream
    set_mode(MODE_LCG);
    queue_word(FUNC_CIPHER, fixup_data(1'b0));
    queue_word(FUNC_CIPHER, fixup_data(1'b1));
    queue_word(FUNC_CIPHER, 8'h00);
    queue_word(FUNC_CIPHER, 8'hff);
    top_key = key_for_byte(BYTE_MAX);
    queue_word(FUNC_LOAD, top_key);
    queue_word(FUNC_CIPHER, 8'hff);      // keystream 255 equal to data
    queue_word(FUNC_LOAD, top_key);
    queue_word(FUNC_CIPHER, 8'h00);      // keystream 255, no wrap fix-up
    queue_word(FUNC_LOAD, 8'h00);
    queue_word(FUNC_LOAD, 8'hff);
    queue_word(FUNC_CIPHER, 8'h80);
    queue_pause();
    queue_word(FUNC_CIPHER, 8'h5a);

    // directed: subtractive keystream
    set_mode(MODE_SUB);
    queue_word(FUNC_CIPHER, 8'h00);
    queue_word(FUNC_CIPHER, fixup_data(1'b0));
    queue_word(FUNC_CIPHER, fixup_data(1'b1));
    queue_word(FUNC_LOAD, 8'h00);
    queue_word(FUNC_LOAD, 8'hff);
    queue_word(FUNC_CIPHER, 8'hff);
    queue_word(FUNC_CIPHER, 8'h00);
    queue_pause();
    queue_word(FUNC_CIPHER, 8'h33);

    // random phases, alternating keystream source
    for (int p = 0; p < PHASES; p++) begin
      set_mode((p % 2 == 0) ? MODE_LCG : MODE_SUB);
      budget = PHASE_WORDS;
      while (budget > 0) begin
        if ($urandom_range(0, 39) == 0) begin
          // reseed run, up to a full delay line
          run = $urandom_range(1, LINE_LEN);
          repeat (run) queue_word(FUNC_LOAD, byte_t'($urandom_range(0, 255)));
          budget -= run;
        end else if ($urandom_range(0, 99) == 0) begin
          queue_pause();
        end else begin
          f = ($urandom_range(0, 4) == 0) ? FUNC_LOAD : FUNC_CIPHER;
          d = byte_t'($urandom_range(0, 255));
          if (f == FUNC_CIPHER && $urandom_range(0, 7) == 0)
            d = fixup_data(1'($urandom_range(0, 1)));
          queue_word(f, d);
          budget--;
        end
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    $display("covered %0d key loads and %0d cipher words over both keystream modes",
             loads_n, ciphers_n);
    $display("%0d cipher words went through the fix-up, %0d errors", fixups_n, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/xksbc_pkg.sv
hdl/xksbc_ram.sv
hdl/xor_keystream_byte_cipher.sv
tb/tb_xor_keystream_byte_cipher.sv
